/* hdl/ssvs_pkg.sv */
`timescale 1ns / 1ps

package ssvs_pkg;

    localparam int KEY_W   = 32;
    localparam int WORD_W  = 32;
    localparam int TOTAL_W = 7;

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [1:0]         t_status;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic               t_action;

    localparam t_action ACT_SET = 1'b0;
    localparam t_action ACT_GET = 1'b1;

    localparam t_status ST_OK           = 2'd0;
    localparam t_status ST_NOT_FOUND    = 2'd1;
    localparam t_status ST_OUT_OF_RANGE = 2'd2;
    localparam t_status ST_FULL         = 2'd3;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_key  key;
        t_word word;
        logic  insert;
        logic  update;
    } t_cell_cmd;

    // What one cell hands to the next one up the chain.
    typedef struct packed {
        t_key  key;
        t_word word;
        logic  valid;
        logic  lt;
    } t_cell_link;

endpackage

/* hdl/ssvs_in_if.sv */
`timescale 1ns / 1ps

interface ssvs_in_if;
    import ssvs_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_key    index;
    t_word   write_value;

    modport source (output valid, output action, output index, output write_value,
                    input ready);
    modport sink   (input valid, input action, input index, input write_value,
                    output ready);
endinterface

/* hdl/ssvs_out_if.sv */
`timescale 1ns / 1ps

interface ssvs_out_if;
    import ssvs_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_word   read_value;
    t_total  entry_total;

    modport source (output valid, output status, output read_value, output entry_total,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_total,
                    output ready);
endinterface

/* hdl/sorted_sparse_vector_store.sv */
`timescale 1ns / 1ps

// Sorted sparse vector store.
// Requests arrive on i_req (action, index, write_value) and each produces
// exactly one response on o_rsp (status, read_value, entry_total).
// The table is a chain of CAPACITY cells kept in ascending key order. Every
// cell compares its key against the request in parallel; an insert moves
// each cell at or above the slot up to its upper neighbor in the same cycle.
// A transaction is accepted whenever the response register is empty or is
// being taken, so one request per cycle is sustained; the response appears
// in the cycle after acceptance. The per-cell key compare and the word select
// across all cells set the cycle time.
// If the receiver stalls, the response is held and i_req.ready drops until
// it is taken; no request is lost.
// Reset empties the table, clears the key range and the response valid flag;
// the block accepts requests in the first cycle after reset.
module sorted_sparse_vector_store #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssvs_in_if.sink    i_req,
    ssvs_out_if.source o_rsp
);
    import ssvs_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_cell_cmd          w_cmd;
    t_cell_link         w_head;
    t_cell_link         w_link [CAPACITY];
    logic [CAPACITY-1:0] w_hit;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_key          r_low;
    t_key          n_low;
    t_key          r_high;
    t_key          n_high;
    logic          r_empty;
    logic          n_empty;

    logic    r_out_valid;
    t_status r_status;
    t_status n_status;
    t_word   r_read;
    t_word   n_read;
    t_total  r_total;

    logic  w_accept;
    logic  w_is_set;
    logic  w_any_hit;
    logic  w_full;
    t_word w_hit_word;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_set    = (i_req.action == ACT_SET);
    assign w_any_hit   = |w_hit;
    assign w_full      = (r_count == CW'(CAPACITY));

    assign w_cmd.key    = i_req.index;
    assign w_cmd.word   = i_req.write_value;
    assign w_cmd.update = w_accept && w_is_set && w_any_hit;
    assign w_cmd.insert = w_accept && w_is_set && !w_any_hit && !w_full;

    // The bottom of the chain behaves as a neighbor holding a smaller key.
    assign w_head.key   = '0;
    assign w_head.word  = '0;
    assign w_head.valid = 1'b1;
    assign w_head.lt    = 1'b1;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ssvs_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (w_cmd),
            .i_prev ((g == 0) ? w_head : w_link[(g == 0) ? 0 : g - 1]),
            .o_link (w_link[g]),
            .o_hit  (w_hit[g])
        );
    end

    // At most one cell matches, so an OR of the gated words selects it.
    always_comb begin
        w_hit_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_word = w_hit_word | (w_link[i].word & {WORD_W{w_hit[i]}});
        end
    end

    always_comb begin
        n_count  = r_count;
        n_low    = r_low;
        n_high   = r_high;
        n_empty  = r_empty;
        n_status = ST_OK;
        n_read   = '0;
        if (w_is_set) begin
            if (!w_any_hit && w_full) begin
                n_status = ST_FULL;
            end else if (w_cmd.insert) begin
                n_count = r_count + CW'(1);
                n_empty = 1'b0;
                if (r_empty || (i_req.index < r_low)) begin
                    n_low = i_req.index;
                end
                if (r_empty || (i_req.index > r_high)) begin
                    n_high = i_req.index;
                end
            end
        end else begin
            if (r_empty || (i_req.index < r_low) || (i_req.index > r_high)) begin
                n_status = ST_OUT_OF_RANGE;
            end else if (w_any_hit) begin
                n_read = w_hit_word;
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_read   <= n_read;
            r_total  <= t_total'(n_count);
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_low   <= n_low;
                r_high  <= n_high;
                r_empty <= n_empty;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.read_value  = r_read;
    assign o_rsp.entry_total = r_total;

endmodule

/* hdl/ssvs_cell.sv */
`timescale 1ns / 1ps

module ssvs_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssvs_pkg::t_cell_cmd   i_cmd,
    input  ssvs_pkg::t_cell_link  i_prev,
    output ssvs_pkg::t_cell_link  o_link,
    output logic                  o_hit
);
    import ssvs_pkg::*;

    t_key  r_key;
    t_word r_word;
    logic  r_valid;
    t_key  n_key;
    t_word n_word;
    logic  n_valid;
    logic  w_lt;
    logic  w_hit;

    assign w_lt  = r_valid && (r_key < i_cmd.key);
    assign w_hit = r_valid && (r_key == i_cmd.key);

    always_comb begin
        n_key   = r_key;
        n_word  = r_word;
        n_valid = r_valid;
        // On insert, cells at or above the slot move up by one; the slot itself
        // is the first cell whose lower neighbor still holds a smaller key.
        if (i_cmd.insert && !w_lt) begin
            if (i_prev.lt) begin
                n_key   = i_cmd.key;
                n_word  = i_cmd.word;
                n_valid = 1'b1;
            end else begin
                n_key   = i_prev.key;
                n_word  = i_prev.word;
                n_valid = i_prev.valid;
            end
        end
        if (i_cmd.update && w_hit) begin
            n_word = i_cmd.word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_word <= n_word;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_link.key   = r_key;
    assign o_link.word  = r_word;
    assign o_link.valid = r_valid;
    assign o_link.lt    = w_lt;
    assign o_hit        = w_hit;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import ssvs_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_OPS = 750;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_action action;
        t_key    index;
        t_word   write_value;
    } t_request;

    typedef struct {
        t_status status;
        t_word   read_value;
        t_total  entry_total;
    } t_response;

    logic i_clk;
    logic i_rst_n;

    ssvs_in_if  req_if ();
    ssvs_out_if rsp_if ();

    sorted_sparse_vector_store #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the table used to predict every response.
    t_key  shadow_keys  [CAPACITY];
    t_word shadow_words [CAPACITY];
    int unsigned shadow_count = 0;
    t_key  shadow_low  = '0;
    t_key  shadow_high = '0;
    bit    shadow_empty = 1'b1;

    t_request  request_queue[$];
    t_response pending_responses[$];

    // Stimulus side bookkeeping of which keys have been inserted.
    t_key known_keys[$];
    bit   key_used[t_key];

    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 1;
    int unsigned gap_left       = 0;
    int unsigned stall_mode     = 0;
    bit          req_taken      = 1'b0;
    t_request    next_req;
    t_response   expected_rsp;

    function automatic t_response table_apply(t_action act, t_key key, t_word word);
        t_response   rsp;
        int unsigned slot;
        bit          hit;
        rsp.status     = ST_OK;
        rsp.read_value = '0;
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < key) slot++;
        hit = (slot < shadow_count) && (shadow_keys[slot] == key);
        if (act == ACT_SET) begin
            if (hit) begin
                shadow_words[slot] = word;
            end else if (shadow_count >= CAPACITY) begin
                rsp.status = ST_FULL;
            end else begin
                for (int j = shadow_count; j > slot; j--) begin
                    shadow_keys[j]  = shadow_keys[j-1];
                    shadow_words[j] = shadow_words[j-1];
                end
                shadow_keys[slot]  = key;
                shadow_words[slot] = word;
                if (shadow_empty || key < shadow_low) shadow_low = key;
                if (shadow_empty || key > shadow_high) shadow_high = key;
                shadow_empty = 1'b0;
                shadow_count++;
            end
        end else begin
            if (shadow_empty || key < shadow_low || key > shadow_high) begin
                rsp.status = ST_OUT_OF_RANGE;
            end else if (hit) begin
                rsp.read_value = shadow_words[slot];
            end else begin
                rsp.status = ST_NOT_FOUND;
            end
        end
        rsp.entry_total = t_total'(shadow_count);
        return rsp;
    endfunction

    task automatic add_item(t_action act, t_key key, t_word word);
        t_request req;
        req.action      = act;
        req.index       = key;
        req.write_value = word;
        request_queue.push_back(req);
        if (act == ACT_SET && !key_used.exists(key) && known_keys.size() < CAPACITY) begin
            key_used[key] = 1'b1;
            known_keys.push_back(key);
        end
    endtask

    function automatic t_key pick_known_key();
        if (known_keys.size() == 0) return t_key'($urandom);
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    function automatic t_key pick_new_key();
        t_key k;
        do begin
            case ($urandom_range(3))
                0: k = t_key'($urandom_range(15));
                1: k = 32'hFFFF_FFFF - t_key'($urandom_range(15));
                2: k = pick_known_key() + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
                default: k = t_key'($urandom);
            endcase
        end while (key_used.exists(k));
        return k;
    endfunction

    function automatic t_key pick_lookup_key();
        case ($urandom_range(9))
            0, 1, 2, 3: return pick_known_key();
            4, 5: return pick_known_key() + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
            6: return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return t_key'($urandom);
        endcase
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on %s: expected 0x%08h, got 0x%08h at %0t",
                         name, expected, actual, $realtime);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.action      = ACT_SET;
        req_if.index       = '0;
        req_if.write_value = '0;
        rsp_if.ready       = 1'b0;

        // Directed cases: empty-table lookups, first insert, range edges,
        // inserts at both ends and in the middle, and an update in place.
        add_item(ACT_GET, 32'h0000_0000, 32'h0);
        add_item(ACT_GET, 32'hFFFF_FFFF, 32'h0);
        add_item(ACT_SET, 32'h8000_0000, 32'hFFFF_FFFF);
        add_item(ACT_GET, 32'h8000_0000, 32'h0);
        add_item(ACT_GET, 32'h7FFF_FFFF, 32'h0);
        add_item(ACT_GET, 32'h8000_0001, 32'h0);
        add_item(ACT_SET, 32'h0000_0000, 32'h0000_0000);
        add_item(ACT_SET, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        add_item(ACT_SET, 32'h4000_0000, 32'h5A5A_5A5A);
        add_item(ACT_GET, 32'h0000_0000, 32'h0);
        add_item(ACT_GET, 32'hFFFF_FFFF, 32'h0);
        add_item(ACT_GET, 32'h4000_0001, 32'h0);
        add_item(ACT_SET, 32'h8000_0000, 32'h1234_5678);
        add_item(ACT_GET, 32'h8000_0000, 32'h0);
        add_item(ACT_SET, 32'hC000_0000, 32'hDEAD_BEEF);
        add_item(ACT_GET, 32'h3FFF_FFFF, 32'h0);
        add_item(ACT_GET, 32'hC000_0000, 32'h0);

        // The table only grows, so new keys come slowly enough that
        // roughly the first half of the run sees a partly filled table.
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if ($urandom_range(1)) begin
                add_item(ACT_GET, pick_lookup_key(), t_word'($urandom));
            end else if ($urandom_range(99) < 30) begin
                add_item(ACT_SET, pick_new_key(), pick_word());
            end else begin
                add_item(ACT_SET, pick_known_key(), pick_word());
            end
        end

        // Make sure the full-table cases are reached.
        while (known_keys.size() < CAPACITY) add_item(ACT_SET, pick_new_key(), pick_word());
        add_item(ACT_SET, pick_new_key(), pick_word());
        add_item(ACT_SET, pick_known_key(), pick_word());
        add_item(ACT_GET, pick_known_key(), 32'h0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        do @(posedge i_clk);
        while (request_queue.size() != 0 || req_if.valid || pending_responses.size() != 0);
        repeat (5) @(posedge i_clk);

        if (mismatch_count == 0 && pending_responses.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Request driver and response back-pressure, updated on the falling edge.
    always @(negedge i_clk) begin
        cycle_count++;
        if (cycle_count % 64 == 0) stall_mode = $urandom_range(3);
        case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(1) == 1);
            2: rsp_if.ready <= (cycle_count % 4 == 0);
            default: rsp_if.ready <= (cycle_count % 4 != 1);
        endcase

        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                next_req = request_queue.pop_front();
                req_if.valid       <= 1'b1;
                req_if.action      <= next_req.action;
                req_if.index       <= next_req.index;
                req_if.write_value <= next_req.write_value;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Check responses and predict accepted requests on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (rsp_if.valid && rsp_if.ready) begin
                idle_cycles = 0;
                if (pending_responses.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected response: status %0d value 0x%08h total %0d at %0t",
                                 rsp_if.status, rsp_if.read_value, rsp_if.entry_total,
                                 $realtime);
                end else begin
                    expected_rsp = pending_responses.pop_front();
                    check_field("status", 32'(expected_rsp.status), 32'(rsp_if.status));
                    check_field("read_value", expected_rsp.read_value, rsp_if.read_value);
                    check_field("entry_total", 32'(expected_rsp.entry_total),
                                32'(rsp_if.entry_total));
                end
            end
            if (req_if.valid && req_if.ready) begin
                idle_cycles = 0;
                req_taken   = 1'b1;
                pending_responses.push_back(
                    table_apply(req_if.action, req_if.index, req_if.write_value));
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
